// ===== hw/rtl/pcmbe_pkg.sv =====
// Shared types, mode codes and constants for the PCM big-endian converter.
package pcmbe_pkg;
    localparam int WordW  = 32;
    localparam int CountW = 3;
    localparam int ModeW  = 3;

    typedef enum logic [ModeW-1:0] {
        MODE_U8_FLIP   = 3'd0,
        MODE_LE16_SWAP = 3'd1,
        MODE_BE16_PASS = 3'd2,
        MODE_LE_FLOAT  = 3'd3,
        MODE_BE_FLOAT  = 3'd4,
        MODE_LE32_SWAP = 3'd5,
        MODE_BE32_PASS = 3'd6,
        MODE_UNUSED    = 3'd7
    } t_mode;

    localparam logic [WordW-1:0] FlipWord = 32'h8080_8080;
    localparam logic [WordW-1:0] PosSat   = 32'h7FFF_FFFF;
    localparam logic [WordW-1:0] NegSat   = 32'h8000_0000;

    // Reverse the byte order of a word.
    function automatic logic [WordW-1:0] swap32(input logic [WordW-1:0] w);
        swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction
endpackage

// ===== hw/rtl/pcmbe_float_cvt.sv =====
// Float32 to saturated int32 conversion, scaled by 2^31-1, truncated toward zero.
module pcmbe_float_cvt
    import pcmbe_pkg::*;
(
    input  logic [WordW-1:0] i_bits,
    output logic [WordW-1:0] o_value,
    output logic             o_sat
);
    logic       sgn;
    logic [7:0] expo;
    logic [22:0] frac;
    logic [23:0] mant;
    logic [55:0] prod;    // mant * (2^31-1)
    logic [86:0] shifted;
    logic [31:0] mag;
    logic [7:0]  sh;

    // Value = mant * 2^(expo-150) * (2^31-1); compare magnitude vs 2^31.
    always_comb begin
        sgn  = i_bits[31];
        expo = i_bits[30:23];
        frac = i_bits[22:0];
        mant = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};
        prod = ({32'd0, mant} << 31) - {32'd0, mant};
        shifted = '0;
        mag = '0;
        sh = '0;
        o_sat = 1'b0;
        o_value = '0;
        if (expo == 8'hFF) begin
            // infinity and NaN saturate toward the sign
            o_sat = 1'b1;
            o_value = sgn ? NegSat : PosSat;
        end else if (expo >= 8'd128) begin
            // |value| >= 2.0, so |product| >= 2^32 - 2
            o_sat = 1'b1;
            o_value = sgn ? NegSat : PosSat;
        end else begin
            // shift right by 150-expo (expo 0 acts as 1 for subnormals)
            sh = (expo == 8'd0) ? 8'd149 : 8'd150 - expo;
            shifted = {31'd0, prod} >> sh;
            if (shifted[86:31] != '0) begin
                // magnitude >= 2^31
                if (sgn && shifted[86:31] == 56'd1 && shifted[30:0] == '0
                    && ({31'd0, prod} & ((87'd1 << sh) - 87'd1)) == '0) begin
                    o_value = NegSat;
                end else begin
                    o_sat = 1'b1;
                    o_value = sgn ? NegSat : PosSat;
                end
            end else begin
                mag = shifted[31:0];
                o_value = sgn ? (~mag + 32'd1) : mag;
            end
        end
    end
endmodule

// ===== hw/rtl/pcm_sample_to_big_endian_unit.sv =====
// PCM sample converter: one raw word in, one big-endian word out per cycle.
// An accepted start reaches o_done through the input register and then the result register.
// Throughput: one transaction every cycle; o_busy is always low.
// Reset: synchronous active-low i_rst_n clears the mode register to u8 flip
// and drops the valid pipeline; the receiver cannot stall results.
module pcm_sample_to_big_endian_unit
    import pcmbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ModeW-1:0]  i_cfg_data,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [WordW-1:0]  i_raw_word,
    input  logic [CountW-1:0] i_byte_count,
    output logic              o_done,
    output logic [WordW-1:0]  o_out_word,
    output logic [CountW-1:0] o_out_count,
    output logic              o_clipped
);
    t_mode             r_mode;
    logic              r_in_vld, r_out_vld;
    logic [WordW-1:0]  r_word;
    logic [CountW-1:0] r_cnt;
    logic [WordW-1:0]  n_out;
    logic [CountW-1:0] n_cnt;
    logic              n_clip;
    logic [WordW-1:0]  r_out;
    logic [CountW-1:0] r_ocnt;
    logic              r_clip;
    logic [WordW-1:0]  flt_in, flt_val, mask;
    logic              flt_sat;

    assign o_busy = 1'b0;

    // Hold mode register and valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_U8_FLIP;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= t_mode'(i_cfg_data);
            r_in_vld  <= i_start;
            r_out_vld <= r_in_vld;
        end
    end

    // Capture input and result payloads.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_raw_word;
            r_cnt  <= (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        end
        r_out  <= n_out;
        r_ocnt <= n_cnt;
        r_clip <= n_clip;
    end

    assign flt_in = (r_mode == MODE_BE_FLOAT) ? swap32(r_word) : r_word;

    pcmbe_float_cvt u_fcvt (
        .i_bits  (flt_in),
        .o_value (flt_val),
        .o_sat   (flt_sat)
    );

    // Select conversion by mode, then mask to valid bytes.
    always_comb begin
        n_out  = r_word;
        n_clip = 1'b0;
        n_cnt  = r_cnt;
        case (r_cnt)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            3'd4:    mask = 32'hFFFF_FFFF;
            default: mask = '0;
        endcase
        case (r_mode)
            MODE_U8_FLIP: n_out = r_word ^ FlipWord;
            MODE_LE16_SWAP: begin
                if (r_cnt >= 3'd2) n_out[15:0] = {r_word[7:0], r_word[15:8]};
                if (r_cnt == 3'd4) n_out[31:16] = {r_word[23:16], r_word[31:24]};
            end
            MODE_LE_FLOAT, MODE_BE_FLOAT: begin
                if (r_cnt == 3'd4) begin
                    n_out  = swap32(flt_val);
                    n_clip = flt_sat;
                end
            end
            MODE_LE32_SWAP: if (r_cnt == 3'd4) n_out = swap32(r_word);
            default: n_out = r_word;
        endcase
        n_out = n_out & mask;
    end

    assign o_done      = r_out_vld;
    assign o_out_word  = r_out;
    assign o_out_count = r_ocnt;
    assign o_clipped   = r_clip;

    // Clipping only arises from a full float word.
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_clipped |-> o_out_count == 3'd4)
        else $error("clipped on partial word");
    // Every start yields a result through the input and result registers.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start ##1 1'b1 |=> o_done)
        else $error("lost transaction");
    // Count is never above four.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_out_count <= 3'd4)
        else $error("count range");
endmodule

// ===== bench/pcm_sample_to_big_endian_unit_checker.sv =====
// Checker for the PCM big-endian converter: predicts each result and compares.
`timescale 1ns / 100ps
module pcm_sample_to_big_endian_unit_checker
    import pcmbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ModeW-1:0]  i_cfg_data,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [WordW-1:0]  i_raw_word,
    input  logic [CountW-1:0] i_byte_count,
    input  logic              i_done,
    input  logic [WordW-1:0]  i_out_word,
    input  logic [CountW-1:0] i_out_count,
    input  logic              i_clipped,
    output int                o_pending,
    output int                o_fail_count
);
    typedef struct packed {
        logic [WordW-1:0]  word;
        logic [CountW-1:0] count;
        logic              clipped;
    } t_be_result;

    t_mode      conv_mode;
    t_be_result be_results_due[$];

    // Scale a float32 pattern to a saturated int32, returned big-endian.
    function automatic logic [WordW-1:0] float_to_be_int(input logic [31:0] fbits,
                                                         output logic sat);
        logic [7:0]  exp_f;
        logic [63:0] dbits;
        real         scaled;
        logic [31:0] val;
        exp_f = fbits[30:23];
        sat   = 1'b0;
        if (exp_f == 8'hFF) begin
            // infinity and NaN both saturate toward the sign
            sat = 1'b1;
            val = fbits[31] ? NegSat : PosSat;
        end else if (exp_f == 8'h00) begin
            // zero and subnormals scale to well under one
            val = '0;
        end else begin
            dbits  = {fbits[31], 11'(int'(exp_f) - 127 + 1023), fbits[22:0], 29'd0};
            scaled = $bitstoreal(dbits) * 2147483647.0;
            if (scaled >= 2147483648.0) begin
                sat = 1'b1;
                val = PosSat;
            end else if (scaled <= -2147483649.0) begin
                sat = 1'b1;
                val = NegSat;
            end else begin
                val = 32'($rtoi(scaled));
            end
        end
        return {val[7:0], val[15:8], val[23:16], val[31:24]};
    endfunction

    function automatic t_be_result convert_word(input t_mode m, input logic [31:0] w,
                                                input logic [CountW-1:0] cnt_in);
        t_be_result  res;
        logic [2:0]  cnt;
        logic [31:0] r, mask;
        logic        sat;
        cnt = (cnt_in > 3'd4) ? 3'd4 : cnt_in;
        r   = w;
        sat = 1'b0;
        if (cnt == 3'd0) begin
            res = '0;
            return res;
        end
        mask = (cnt == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * cnt)) - 32'd1);
        case (m)
            MODE_U8_FLIP: r = w ^ FlipWord;
            MODE_LE16_SWAP: begin
                if (cnt >= 2) r[15:0] = {w[7:0], w[15:8]};
                if (cnt == 4) r[31:16] = {w[23:16], w[31:24]};
            end
            MODE_LE_FLOAT: if (cnt == 4) r = float_to_be_int(w, sat);
            MODE_BE_FLOAT: if (cnt == 4)
                r = float_to_be_int({w[7:0], w[15:8], w[23:16], w[31:24]}, sat);
            MODE_LE32_SWAP: if (cnt == 4) r = {w[7:0], w[15:8], w[23:16], w[31:24]};
            default: r = w;
        endcase
        res.word    = r & mask;
        res.count   = cnt;
        res.clipped = sat;
        return res;
    endfunction

    assign o_pending = be_results_due.size();

    // Track the mode, queue predictions on accept, compare on done.
    always @(posedge i_clk) begin
        t_be_result got, want;
        int         errs;
        errs = 0;
        if (!i_rst_n) begin
            conv_mode = MODE_U8_FLIP;
            be_results_due.delete();
        end else begin
            if (i_done) begin
                got = '{i_out_word, i_out_count, i_clipped};
                if (be_results_due.size() == 0) begin
                    $error("unexpected transaction: word %h count %0d", got.word, got.count);
                    errs++;
                end else begin
                    want = be_results_due.pop_front();
                    if (got.word !== want.word) begin
                        $error("out_word: expected %h, actual %h", want.word, got.word);
                        errs++;
                    end
                    if (got.count !== want.count) begin
                        $error("out_count: expected %0d, actual %0d", want.count, got.count);
                        errs++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $error("clipped: expected %b, actual %b", want.clipped, got.clipped);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
            if (i_start && !i_busy)
                be_results_due.push_back(convert_word(conv_mode, i_raw_word, i_byte_count));
            if (i_cfg_we) conv_mode = t_mode'(i_cfg_data);
        end
    end

    initial o_fail_count = 0;
endmodule

// ===== bench/pcm_sample_to_big_endian_unit_tb.sv =====
// Testbench top for the PCM big-endian converter: stimulus and verdict.
`timescale 1ns / 100ps
module pcm_sample_to_big_endian_unit_tb;
    import pcmbe_pkg::*;

    localparam int CycleLimit = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [ModeW-1:0]  i_cfg_data = '0;
    logic              i_start = 1'b0;
    logic [WordW-1:0]  i_raw_word = '0;
    logic [CountW-1:0] i_byte_count = 3'd4;
    logic              o_busy, o_done, o_clipped;
    logic [WordW-1:0]  o_out_word;
    logic [CountW-1:0] o_out_count;
    int                pending, fail_count;
    int                cycle_count = 0;
    bit                no_idle;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pcm_sample_to_big_endian_unit DUT (.*);

    pcm_sample_to_big_endian_unit_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_start,
        .i_busy(o_busy), .i_raw_word, .i_byte_count,
        .i_done(o_done), .i_out_word(o_out_word), .i_out_count(o_out_count),
        .i_clipped(o_clipped), .o_pending(pending), .o_fail_count(fail_count)
    );

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one transaction and hold it until accepted.
    task automatic send_sample(input logic [31:0] w, input logic [2:0] cnt);
        logic busy_s;
        if (!no_idle) begin
            while ($urandom_range(99) < 34) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start      <= 1'b1;
        i_raw_word   <= w;
        i_byte_count <= cnt;
        forever begin
            @(negedge i_clk) busy_s = o_busy;
            @(posedge i_clk);
            if (!busy_s) break;
        end
    endtask

    // Drop start and wait until every result has come back.
    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_float(input bit be);
        logic [31:0] f;
        case ($urandom_range(9))
            0: f = 32'h3F80_0000;                         // +1.0
            1: f = 32'hBF80_0000;                         // -1.0
            2: f = 32'h7F80_0000 | {1'($urandom_range(1)), 31'd0};   // infinity
            3: f = {1'($urandom), 8'hFF, 23'($urandom_range(1, 8388607))}; // NaN
            4: f = {1'($urandom), 8'($urandom_range(127, 140)), 23'($urandom)}; // overflow
            5: f = {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)}; // tiny
            6: f = {1'($urandom), 8'h7E, 23'($urandom_range(8388600, 8388607))};
            default: f = {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
        endcase
        return be ? {f[7:0], f[15:8], f[23:16], f[31:24]} : f;
    endfunction

    initial begin
        t_mode       mode_order[7];
        logic [31:0] w;
        logic [2:0]  cnt;
        bit          is_be;
        mode_order = '{MODE_BE32_PASS, MODE_LE_FLOAT, MODE_U8_FLIP, MODE_LE16_SWAP,
                       MODE_BE_FLOAT, MODE_BE16_PASS, MODE_LE32_SWAP};
        no_idle = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset mode first, then every mode in turn.
        for (int p = -1; p < 7; p++) begin
            if (p >= 0) write_mode(mode_order[p]);
            // Field extremes and partial trailing words.
            for (int c = 1; c <= 4; c++) begin
                send_sample(32'h0000_0000, 3'(c));
                send_sample(32'hFFFF_FFFF, 3'(c));
                send_sample(32'h1234_5678, 3'(c));
            end
            if (p < 0) continue;
            is_be = (mode_order[p] == MODE_BE_FLOAT);
            for (int k = 0; k < 6; k++) send_sample(pick_float(is_be), 3'd4);
            // Random words; one stretch runs with no idling.
            for (int k = 0; k < 90; k++) begin
                no_idle = (k >= 30 && k < 55);
                if (mode_order[p] inside {MODE_LE_FLOAT, MODE_BE_FLOAT} && $urandom_range(1))
                    w = pick_float(is_be);
                else
                    w = $urandom;
                cnt = ($urandom_range(3) == 0) ? 3'($urandom_range(1, 3)) : 3'd4;
                send_sample(w, cnt);
                // Let the pipeline run dry once per phase.
                if (k == 60) drain();
            end
            no_idle = 1'b0;
        end

        drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
